// ===== sv/qte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the quaternion to
// Euler angle unit. Depends on nothing.
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN = 24;
  localparam int SQRT_CELLS = 31;
  localparam int VEC_W = 35;
  localparam int XY_W = 40;
  localparam int Z_W = 34;
  localparam int SQ_W = 62;
  localparam logic signed [VEC_W-1:0] ONE_Q28 = VEC_W'(1) <<< 28;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(34'sh06487ED51);
  localparam logic [30:0] DEG_SCALE = 31'd961263669;

  typedef struct packed {
    logic signed [VEC_W-1:0] sr;
    logic signed [VEC_W-1:0] cr;
    logic signed [VEC_W-1:0] sy;
    logic signed [VEC_W-1:0] cy;
  } ryv_t;

  typedef struct packed {
    ryv_t ry;
    logic [SQ_W-1:0] va;
    logic [SQ_W-1:0] ra;
    logic [SQ_W-1:0] vb;
    logic [SQ_W-1:0] rb;
  } sq_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } cd_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'h3243F6A8;
      1: v = 32'h1DAC6705;
      2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;
      4: v = 32'h03FEAB76;
      5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;
      7: v = 32'h007FFF55;
      8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return Z_W'(signed'({2'b00, v}));
  endfunction

endpackage

// ===== sv/qte_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for quaternion words and angle words.
// Depends on nothing.
interface qte_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

// ===== sv/qte_front.sv =====
`timescale 1ns / 1ps
// Front end: component products, then quadratic forms and clamped root
// arguments, two pipeline stages. Depends on qte_pkg.
module qte_front import qte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] w,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [15:0] z,
  output logic out_valid,
  input  logic out_ready,
  output sq_t out_data
);

  logic v1;
  logic rdy1;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_xz, p_wz, p_xy, p_zz;
  logic signed [VEC_W-1:0] s2, a2, b2;
  sq_t d2_next;

  assign rdy1 = !out_valid || out_ready;
  assign in_ready = !v1 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_ready && in_valid) begin
      p_wx <= w * x;
      p_yz <= y * z;
      p_xx <= x * x;
      p_yy <= y * y;
      p_wy <= w * y;
      p_xz <= x * z;
      p_wz <= w * z;
      p_xy <= x * y;
      p_zz <= z * z;
    end
  end

  always_comb begin
    s2 = VEC_W'(p_wy) - VEC_W'(p_xz);
    a2 = ONE_Q28 + (s2 <<< 1);
    b2 = ONE_Q28 - (s2 <<< 1);
    d2_next.ry.sr = (VEC_W'(p_wx) + VEC_W'(p_yz)) <<< 1;
    d2_next.ry.cr = ONE_Q28 - ((VEC_W'(p_xx) + VEC_W'(p_yy)) <<< 1);
    d2_next.ry.sy = (VEC_W'(p_wz) + VEC_W'(p_xy)) <<< 1;
    d2_next.ry.cy = ONE_Q28 - ((VEC_W'(p_yy) + VEC_W'(p_zz)) <<< 1);
    d2_next.va = a2[VEC_W-1] ? '0 : (SQ_W'(a2[32:0]) << 28);
    d2_next.vb = b2[VEC_W-1] ? '0 : (SQ_W'(b2[32:0]) << 28);
    d2_next.ra = '0;
    d2_next.rb = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy1) begin
      out_valid <= v1;
    end
    if (rdy1 && v1) begin
      out_data <= d2_next;
    end
  end

endmodule

// ===== sv/qte_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One digit of the two square roots; the roll and yaw vectors ride along.
// Depends on qte_pkg.
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t out_data
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * IDX);

  logic [SQ_W-1:0] ta, tb;
  sq_t d_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    d_next = in_data;
    ta = in_data.ra + BIT;
    tb = in_data.rb + BIT;
    if (in_data.va >= ta) begin
      d_next.va = in_data.va - ta;
      d_next.ra = (in_data.ra >> 1) + BIT;
    end else begin
      d_next.ra = in_data.ra >> 1;
    end
    if (in_data.vb >= tb) begin
      d_next.vb = in_data.vb - tb;
      d_next.rb = (in_data.rb >> 1) + BIT;
    end else begin
      d_next.rb = in_data.rb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

// ===== sv/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
// One vectoring CORDIC iteration on the roll, pitch and yaw lanes.
// Depends on qte_pkg.
module qte_cordic_cell import qte_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cd_t out_data
);

  localparam logic signed [Z_W-1:0] ANG = atan_q30(IDX);

  function automatic lane_t step(input lane_t l);
    lane_t r;
    r = l;
    if (!l.y[XY_W-1]) begin
      r.x = l.x + (l.y >>> IDX);
      r.y = l.y - (l.x >>> IDX);
      r.z = l.z + ANG;
    end else begin
      r.x = l.x - (l.y >>> IDX);
      r.y = l.y + (l.x >>> IDX);
      r.z = l.z - ANG;
    end
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data.roll <= step(in_data.roll);
      out_data.pitch <= step(in_data.pitch);
      out_data.yaw <= step(in_data.yaw);
    end
  end

endmodule

// ===== sv/qte_back.sv =====
`timescale 1ns / 1ps
// Back end: pitch correction, unit scaling, rounding and saturation,
// two pipeline stages ending in the output register. Depends on qte_pkg.
module qte_back import qte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic degrees,
  input  logic in_valid,
  output logic in_ready,
  input  cd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic signed [15:0] yaw_angle
);

  localparam logic signed [65:0] DEG66 = 66'(signed'({1'b0, DEG_SCALE}));

  logic v1;
  logic rdy2;
  logic signed [35:0] ang [3];
  logic signed [65:0] prod [3];
  logic signed [35:0] ang_next [3];
  logic signed [15:0] res_next [3];

  function automatic logic signed [35:0] zang(input lane_t l);
    return l.zero ? 36'sd0 : 36'(l.z);
  endfunction

  function automatic logic signed [15:0] finish(input logic signed [35:0] a,
                                                input logic signed [65:0] p,
                                                input logic deg);
    logic signed [65:0] t;
    logic signed [19:0] r;
    if (deg) begin
      t = (p + (66'sd1 <<< 46)) >>> 47;
    end else begin
      t = (66'(a) + 66'sd65536) >>> 17;
    end
    r = 20'(t);
    if (r > 20'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -20'sd32768) begin
      return 16'sh8000;
    end
    return 16'(r);
  endfunction

  assign rdy2 = !out_valid || out_ready;
  assign in_ready = !v1 || rdy2;

  always_comb begin
    ang_next[0] = zang(in_data.roll);
    ang_next[1] = (zang(in_data.pitch) <<< 1) - 36'(HALF_PI_Q30);
    ang_next[2] = zang(in_data.yaw);
    for (int i = 0; i < 3; i++) begin
      res_next[i] = finish(ang[i], prod[i], degrees);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_ready && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        ang[i] <= ang_next[i];
        prod[i] <= 66'(ang_next[i]) * DEG66;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
    if (rdy2 && v1) begin
      roll_angle <= res_next[0];
      pitch_angle <= res_next[1];
      yaw_angle <= res_next[2];
    end
  end

endmodule

// ===== sv/quaternion_to_euler_angles_unit.sv =====
`timescale 1ns / 1ps
// Quaternion to ZYX Euler angles, top level.
// Depends on qte_pkg, qte_if, qte_front, qte_sqrt_cell, qte_cordic_cell, qte_back.
//
// Usage: quat_in takes one word of four signed Q1.14 components; angle_out
// gives roll, pitch and yaw as one word, in radians Q2.13 or, with
// output_degrees set through cfg_wr_en and cfg_wr_data, degrees Q8.7.
// The block is a chain of registered cells: two front stages, 31 square
// root cells (one result digit each), CORDIC_STAGES CORDIC cells and two
// back stages. One word is accepted every cycle unless a receiver stall
// has filled the chain. Each cell moves its word on when the next cell is
// empty or moving, so bubbles close up and the block keeps accepting words
// while a finished result waits at the output.
// A receiver stall holds the output word stable; once every cell is full,
// quat_in.ready falls. Synchronous reset empties all cells and sets the
// output to radians.
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  qte_in_if.sink quat_in,
  qte_out_if.source angle_out,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data
);

  logic output_degrees;

  logic s_valid [SQRT_CELLS+1];
  logic s_ready [SQRT_CELLS+1];
  sq_t s_data [SQRT_CELLS+1];
  logic c_valid [CORDIC_STAGES+1];
  logic c_ready [CORDIC_STAGES+1];
  cd_t c_data [CORDIC_STAGES+1];

  logic signed [XY_W-1:0] px, py;

  function automatic lane_t prerot(input logic signed [XY_W-1:0] y,
                                   input logic signed [XY_W-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x[XY_W-1]) begin
      if (!y[XY_W-1]) begin
        l.x = y;
        l.y = -x;
        l.z = HALF_PI_Q30;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -HALF_PI_Q30;
      end
    end
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      output_degrees <= 1'b0;
    end else if (cfg_wr_en) begin
      output_degrees <= cfg_wr_data;
    end
  end

  qte_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(quat_in.valid), .in_ready(quat_in.ready),
    .w(quat_in.quat_w), .x(quat_in.quat_x), .y(quat_in.quat_y), .z(quat_in.quat_z),
    .out_valid(s_valid[0]), .out_ready(s_ready[0]), .out_data(s_data[0])
  );

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    qte_sqrt_cell #(.IDX(k)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(s_valid[k]), .in_ready(s_ready[k]), .in_data(s_data[k]),
      .out_valid(s_valid[k+1]), .out_ready(s_ready[k+1]), .out_data(s_data[k+1])
    );
  end

  assign py = XY_W'(signed'({1'b0, s_data[SQRT_CELLS].ra[XY_W-2:0]}));
  assign px = XY_W'(signed'({1'b0, s_data[SQRT_CELLS].rb[XY_W-2:0]}));
  assign c_valid[0] = s_valid[SQRT_CELLS];
  assign s_ready[SQRT_CELLS] = c_ready[0];
  assign c_data[0].roll = prerot(XY_W'(s_data[SQRT_CELLS].ry.sr),
                                 XY_W'(s_data[SQRT_CELLS].ry.cr));
  assign c_data[0].pitch = prerot(py, px);
  assign c_data[0].yaw = prerot(XY_W'(s_data[SQRT_CELLS].ry.sy),
                                XY_W'(s_data[SQRT_CELLS].ry.cy));

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qte_cordic_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(c_valid[i]), .in_ready(c_ready[i]), .in_data(c_data[i]),
      .out_valid(c_valid[i+1]), .out_ready(c_ready[i+1]), .out_data(c_data[i+1])
    );
  end

  qte_back u_back (
    .clk(clk), .rst(rst), .degrees(output_degrees),
    .in_valid(c_valid[CORDIC_STAGES]), .in_ready(c_ready[CORDIC_STAGES]),
    .in_data(c_data[CORDIC_STAGES]),
    .out_valid(angle_out.valid), .out_ready(angle_out.ready),
    .roll_angle(angle_out.roll_angle), .pitch_angle(angle_out.pitch_angle),
    .yaw_angle(angle_out.yaw_angle)
  );

endmodule
